// ===== hw/rtl/glc_pkg.sv =====
`default_nettype none

package glc_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned FACE_W    = 8;
  localparam int unsigned GLYPH_W   = 16;
  localparam int unsigned KEY_W     = FACE_W + GLYPH_W;
  localparam int unsigned SLOT_W    = 6;

  typedef struct packed {
    logic [FACE_W-1:0]  face_index;
    logic [GLYPH_W-1:0] glyph_code;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               evicted;
    logic [FACE_W-1:0]  old_face;
    logic [GLYPH_W-1:0] old_glyph;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic start;      // latch request key, restart the scan
    logic scan;       // read next key entry, compare the one read before
    logic sel_hit;    // take the matching slot
    logic sel_evict;  // take the lru slot (list head)
    logic append;     // give out the next unused slot
    logic link_rd;    // read list links and key of the chosen slot
    logic link_wr1;   // unlink the chosen slot
    logic link_wr2;   // relink the chosen slot at the mru end
    logic finish;     // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic used_zero;
    logic full;
    logic match;
    logic match_tail;
    logic scan_last;
    logic res_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/glc_ctrl.sv =====
`default_nettype none

module glc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output glc_pkg::cmd_t      cmd,
  input  wire glc_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    IDLE, SCAN, APPEND, LINK_RD, LINK_WR1, LINK_WR2, DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.used_zero ? APPEND : SCAN;
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          cmd.sel_hit = 1'b1;
          state_next  = sts.match_tail ? DONE : LINK_RD;
        end else if (sts.scan_last) begin
          if (sts.full) begin
            cmd.sel_evict = 1'b1;
            state_next    = LINK_RD;
          end else begin
            state_next = APPEND;
          end
        end
      end
      APPEND: begin
        cmd.append = 1'b1;
        state_next = DONE;
      end
      LINK_RD: begin
        cmd.link_rd = 1'b1;
        state_next  = LINK_WR1;
      end
      LINK_WR1: begin
        cmd.link_wr1 = 1'b1;
        state_next   = LINK_WR2;
      end
      LINK_WR2: begin
        cmd.link_wr2 = 1'b1;
        state_next   = DONE;
      end
      DONE: begin
        if (sts.res_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/glc_dp.sv =====
`default_nettype none

module glc_dp #(
  parameter int unsigned SLOTS = glc_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire glc_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output glc_pkg::rsp_t      out_data,
  input  wire glc_pkg::cmd_t cmd,
  output glc_pkg::sts_t      sts
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned KW = glc_pkg::KEY_W;
  localparam int unsigned SW = glc_pkg::SLOT_W;

  // storage, contents undefined until written
  logic [KW-1:0] key_mem  [SLOTS];
  logic [IW-1:0] next_mem [SLOTS];
  logic [IW-1:0] prev_mem [SLOTS];

  logic [KW-1:0] req_key;
  logic [CW-1:0] used;
  logic [IW-1:0] head, tail;
  logic [IW-1:0] scan_idx, rd_idx, sel_slot;
  logic          rd_vld;
  logic [KW-1:0] rd_key, old_key;
  logic [IW-1:0] rd_next, rd_prev;
  logic          hit_flag, evict_flag;

  logic [IW-1:0]    used_slot, key_raddr, key_waddr, nx_waddr, nx_wdata, pv_waddr, pv_wdata;
  logic             key_we, nx_we, pv_we, is_head;
  logic [IW+SW-1:0] slot_wide;

  assign used_slot = used[IW-1:0];
  assign is_head   = (sel_slot == head);
  assign key_raddr = cmd.link_rd ? sel_slot : scan_idx;

  // key memory write port
  always_comb begin
    key_we    = cmd.append | (cmd.link_wr1 & evict_flag);
    key_waddr = cmd.append ? used_slot : sel_slot;
  end

  // list link write ports
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = tail;
    nx_wdata = sel_slot;
    pv_we    = 1'b0;
    pv_waddr = sel_slot;
    pv_wdata = tail;
    if (cmd.append) begin
      nx_we    = (used != '0);
      nx_wdata = used_slot;
      pv_we    = (used != '0);
      pv_waddr = used_slot;
    end else if (cmd.link_wr1) begin
      nx_we    = ~is_head;
      nx_waddr = rd_prev;
      nx_wdata = rd_next;
      pv_we    = 1'b1;
      pv_waddr = rd_next;
      pv_wdata = rd_prev;
    end else if (cmd.link_wr2) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_key  <= key_mem[key_raddr];
    rd_next <= next_mem[sel_slot];
    rd_prev <= prev_mem[sel_slot];
    if (key_we) begin
      key_mem[key_waddr] <= req_key;
    end
    if (nx_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
    if (pv_we) begin
      prev_mem[pv_waddr] <= pv_wdata;
    end
  end

  // scan, selection and list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan & (CW'(scan_idx) < used);
      if (cmd.append) begin
        used <= used + CW'(1);
      end
    end
    rd_idx <= scan_idx;
    if (cmd.start) begin
      req_key    <= {in_data.face_index, in_data.glyph_code};
      scan_idx   <= '0;
      hit_flag   <= 1'b0;
      evict_flag <= 1'b0;
      old_key    <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + IW'(1);
    end
    if (cmd.sel_hit) begin
      sel_slot <= rd_idx;
      hit_flag <= 1'b1;
    end
    if (cmd.sel_evict) begin
      sel_slot   <= head;
      evict_flag <= 1'b1;
    end
    if (cmd.append) begin
      sel_slot <= used_slot;
      tail     <= used_slot;
      if (used == '0) begin
        head <= used_slot;
      end
    end
    if (cmd.link_wr1) begin
      if (is_head) begin
        head <= rd_next;
      end
      if (evict_flag) begin
        old_key <= rd_key;
      end
    end
    if (cmd.link_wr2) begin
      tail <= sel_slot;
    end
  end

  // result register
  assign slot_wide = {{SW{1'b0}}, sel_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      out_data.slot      <= slot_wide[SW-1:0];
      out_data.hit       <= hit_flag;
      out_data.evicted   <= evict_flag;
      out_data.old_face  <= old_key[KW-1:glc_pkg::GLYPH_W];
      out_data.old_glyph <= old_key[glc_pkg::GLYPH_W-1:0];
    end
  end

  always_comb begin
    sts.used_zero  = (used == '0);
    sts.full       = (used == CW'(SLOTS));
    sts.match      = rd_vld & (rd_key == req_key);
    sts.match_tail = (rd_idx == tail);
    sts.scan_last  = rd_vld & (CW'(rd_idx) == (used - CW'(1)));
    sts.res_free   = ~out_valid | out_ready;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(SLOTS))
    else $error("slot count beyond capacity");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    cmd.sel_evict |-> sts.full)
    else $error("eviction while free slots remain");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> used == $past(used) + CW'(1))
    else $error("slot count did not advance on append");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.evicted))
    else $error("result marked both hit and evicted");

endmodule

`default_nettype wire

// ===== hw/rtl/glyph_slot_lru_cache.sv =====
`default_nettype none

// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data  (glc_pkg::req_t)
// out       output     out_valid / out_ready out_data (glc_pkg::rsp_t)
//
// one lookup at a time; the key memory has one read port, so a lookup scans
// the filled slots one per cycle; a miss appends to a free slot (with no
// scan when empty) or, if full, evicts the lru slot; in_ready is high in idle
// reset clears slot count, read and result valid, and state only; no clearing pass
// a stalled out channel holds the finished result; the next item is taken
// meanwhile and waits in its last step until the result register frees
module glyph_slot_lru_cache #(
  parameter int unsigned SLOTS = glc_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire glc_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output glc_pkg::rsp_t      out_data
);

  // recency is kept as a doubly linked list over slots in two link memories:
  // head is least recently used, tail most recently used, so a hit off the tail
  // or an eviction reads, unlinks and relinks one slot instead of shifting the order
  glc_pkg::cmd_t cmd;
  glc_pkg::sts_t sts;

  // sequencer: scan, choose slot, relink, hand over result
  glc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // key store, link memories, pointers, slot count and result register
  glc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
